@@ rtl/hcd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared widths, constants and status codes of the Hamming codeword decoder.
// ----------------------------------------------------------------------------
package hcd_pkg;

   localparam int WORD_SIZE_W       = 7;
   localparam int DEF_MAX_WORD_BITS = 64;
   localparam int MIN_WORD_BITS     = 3;
   localparam int RESET_WORD_BITS   = 12;
   localparam int STATUS_W          = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_CLEAN         = 2'd0,
      STATUS_CHECK_ERR     = 2'd1,
      STATUS_CORRECTED     = 2'd2,
      STATUS_UNCORRECTABLE = 2'd3
   } status_type;

   function automatic int syn_width(input int max_bits);
      return $clog2(max_bits + 1);
   endfunction

   function automatic int data_width(input int max_bits);
      return max_bits - syn_width(max_bits);
   endfunction

   function automatic int count_width(input int max_bits);
      return $clog2(data_width(max_bits) + 1);
   endfunction

   function automatic int req_width(input int max_bits);
      return ((max_bits + 7) / 8) * 8;
   endfunction

   function automatic int rsp_width(input int max_bits);
      return ((data_width(max_bits) + count_width(max_bits) + syn_width(max_bits)
               + STATUS_W + 7) / 8) * 8;
   endfunction

endpackage

@@ rtl/hcd_syndrome.sv @@
// ----------------------------------------------------------------------------
// hcd_syndrome
// Parity trees: syndrome bit b is the parity of all positions with bit b set.
// ----------------------------------------------------------------------------
module hcd_syndrome #(
   parameter int MAX_WORD_BITS = hcd_pkg::DEF_MAX_WORD_BITS
) (
   input  logic [MAX_WORD_BITS-1:0]                   word,
   output logic [hcd_pkg::syn_width(MAX_WORD_BITS)-1:0] syndrome
);
   import hcd_pkg::*;

   localparam int SYN_W = syn_width(MAX_WORD_BITS);

   always_comb begin
      syndrome = '0;
      for (int b = 0; b < SYN_W; b++) begin
         for (int p = 1; p <= MAX_WORD_BITS; p++) begin
            if (((p >> b) & 1) != 0) begin
               syndrome[b] = syndrome[b] ^ word[p-1];
            end
         end
      end
   end

endmodule

@@ rtl/hamming_codeword_decoder.sv @@
// ----------------------------------------------------------------------------
// hamming_codeword_decoder
// Single-error-correcting Hamming decoder with a run-time codeword length.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one codeword per transaction, Hamming position k in bit k-1.
//   rsp_* returns data bits (first data bit most significant), data count,
//   syndrome and status: clean, check bit error, corrected, uncorrectable.
//   csr_wr_en/csr_wr_data set the codeword length (3..MAX_WORD_BITS, values
//   outside are clamped); write it only while the pipeline is empty.
// Pipeline: req transaction to rsp_tvalid through mask and count, syndrome
//   trees, correction and compaction, and the final alignment shift.
// Throughput: one codeword per cycle while rsp is not stalled; each stage holds one item.
// Reset: synchronous; empties the pipeline, codeword length returns to 12.
// Stall: a stage holds its item while the stage after it is full and stalled;
//   empty stages keep filling, so a stalled rsp leaves up to 4 items in the
//   pipeline, the stalled one included, before req_tready drops.
// ----------------------------------------------------------------------------
module hamming_codeword_decoder #(
   parameter int MAX_WORD_BITS = hcd_pkg::DEF_MAX_WORD_BITS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // codeword
   input  logic [hcd_pkg::req_width(MAX_WORD_BITS)-1:0]  req_tdata,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // data_bits, data_count, syndrome, status
   output logic [hcd_pkg::rsp_width(MAX_WORD_BITS)-1:0]  rsp_tdata,
   input  logic                                          csr_wr_en,
   input  logic [hcd_pkg::WORD_SIZE_W-1:0]               csr_wr_data
);
   import hcd_pkg::*;

   localparam int SYN_W  = syn_width(MAX_WORD_BITS);
   localparam int DATA_W = data_width(MAX_WORD_BITS);
   localparam int CNT_W  = count_width(MAX_WORD_BITS);
   localparam int CNT_LO = DATA_W;
   localparam int SYN_LO = DATA_W + CNT_W;
   localparam int STS_LO = DATA_W + CNT_W + SYN_W;

   localparam logic [WORD_SIZE_W-1:0] MAX_N = WORD_SIZE_W'(MAX_WORD_BITS);
   localparam logic [WORD_SIZE_W-1:0] MIN_N = WORD_SIZE_W'(MIN_WORD_BITS);
   localparam logic [WORD_SIZE_W-1:0] RST_N = WORD_SIZE_W'(RESET_WORD_BITS);

   logic [WORD_SIZE_W-1:0]   word_size_ff;

   logic                     ld1, ld2, ld3, ld4;

   logic [WORD_SIZE_W-1:0]   n_eff;
   logic [WORD_SIZE_W-1:0]   npow;
   logic [MAX_WORD_BITS-1:0] word1_in;
   logic [CNT_W-1:0]         cnt1_in;

   logic                     v1_ff, v2_ff, v3_ff, v4_ff;
   logic [MAX_WORD_BITS-1:0] word1_ff, word2_ff;
   logic [WORD_SIZE_W-1:0]   n1_ff, n2_ff;
   logic [CNT_W-1:0]         cnt1_ff, cnt2_ff, cnt3_ff, cnt4_ff;
   logic [SYN_W-1:0]         syn2_in;
   logic [SYN_W-1:0]         syn2_ff, syn3_ff, syn4_ff;
   status_type               sts3_in, sts3_ff, sts4_ff;
   logic [MAX_WORD_BITS-1:0] fixed_word;
   logic [DATA_W-1:0]        compact;
   logic [DATA_W-1:0]        r3_ff;
   logic [CNT_W-1:0]         shamt;
   logic [DATA_W-1:0]        data4_in, data4_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         word_size_ff <= RST_N;
      end else if (csr_wr_en) begin
         word_size_ff <= csr_wr_data;
      end
   end

   // per-stage advance
   assign ld4        = !v4_ff || rsp_tready;
   assign ld3        = !v3_ff || ld4;
   assign ld2        = !v2_ff || ld3;
   assign ld1        = !v1_ff || ld2;
   assign req_tready = ld1;

   // stage 1: clamp length, mask unused bits, data count
   always_comb begin
      if (word_size_ff < MIN_N) begin
         n_eff = MIN_N;
      end else if (word_size_ff > MAX_N) begin
         n_eff = MAX_N;
      end else begin
         n_eff = word_size_ff;
      end
      for (int i = 0; i < MAX_WORD_BITS; i++) begin
         word1_in[i] = req_tdata[i] && (WORD_SIZE_W'(i) < n_eff);
      end
      npow = '0;
      for (int b = 0; b < SYN_W; b++) begin
         if ({1'b0, n_eff} >= (WORD_SIZE_W+1)'(1 << b)) begin
            npow = npow + 1'b1;
         end
      end
      cnt1_in = CNT_W'(n_eff - npow);
   end

   // stage 2: syndrome
   hcd_syndrome #(
      .MAX_WORD_BITS(MAX_WORD_BITS)
   ) u_hcd_syndrome (
      .word     (word1_ff),
      .syndrome (syn2_in)
   );

   // stage 3: classify, correct, compact
   always_comb begin
      if (syn2_ff == '0) begin
         sts3_in = STATUS_CLEAN;
      end else if ($onehot(syn2_ff)) begin
         sts3_in = STATUS_CHECK_ERR;
      end else if (int'(syn2_ff) > int'(n2_ff)) begin
         sts3_in = STATUS_UNCORRECTABLE;
      end else begin
         sts3_in = STATUS_CORRECTED;
      end
      for (int i = 0; i < MAX_WORD_BITS; i++) begin
         fixed_word[i] = word2_ff[i] ^
                         ((sts3_in == STATUS_CORRECTED) && (syn2_ff == SYN_W'(i + 1)));
      end
   end

   for (genvar p = 1; p <= MAX_WORD_BITS; p++) begin : g_compact
      if ((p & (p - 1)) != 0) begin : g_data
         assign compact[DATA_W - p + $clog2(p + 1)] = fixed_word[p-1];
      end
   end

   // stage 4: right-align to the data count
   assign shamt    = CNT_W'(DATA_W) - cnt3_ff;
   assign data4_in = r3_ff >> shamt;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ld1) v1_ff <= req_tvalid;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
         if (ld4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1 && req_tvalid) begin
         word1_ff <= word1_in;
         n1_ff    <= n_eff;
         cnt1_ff  <= cnt1_in;
      end
      if (ld2 && v1_ff) begin
         word2_ff <= word1_ff;
         n2_ff    <= n1_ff;
         cnt2_ff  <= cnt1_ff;
         syn2_ff  <= syn2_in;
      end
      if (ld3 && v2_ff) begin
         r3_ff   <= compact;
         cnt3_ff <= cnt2_ff;
         syn3_ff <= syn2_ff;
         sts3_ff <= sts3_in;
      end
      if (ld4 && v3_ff) begin
         data4_ff <= data4_in;
         cnt4_ff  <= cnt3_ff;
         syn4_ff  <= syn3_ff;
         sts4_ff  <= sts3_ff;
      end
   end

   assign rsp_tvalid = v4_ff;

   always_comb begin
      rsp_tdata                            = '0;
      rsp_tdata[DATA_W-1:0]                = data4_ff;
      rsp_tdata[CNT_LO +: CNT_W]           = cnt4_ff;
      rsp_tdata[SYN_LO +: SYN_W]           = syn4_ff;
      rsp_tdata[STS_LO +: STATUS_W]        = sts4_ff;
   end

endmodule

@@ rtl/hcd_checker.sv @@
// ----------------------------------------------------------------------------
// hcd_checker
// Port-level checks of the Hamming codeword decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hcd_checker #(
   parameter int MAX_WORD_BITS = hcd_pkg::DEF_MAX_WORD_BITS
) (
   input logic                                          clock,
   input logic                                          reset,
   input logic                                          rsp_tvalid,
   input logic                                          rsp_tready,
   input logic [hcd_pkg::rsp_width(MAX_WORD_BITS)-1:0]  rsp_tdata
);
   import hcd_pkg::*;

   localparam int SYN_W  = syn_width(MAX_WORD_BITS);
   localparam int DATA_W = data_width(MAX_WORD_BITS);
   localparam int CNT_W  = count_width(MAX_WORD_BITS);
   localparam int CNT_LO = DATA_W;
   localparam int SYN_LO = DATA_W + CNT_W;
   localparam int STS_LO = DATA_W + CNT_W + SYN_W;

   logic [DATA_W-1:0]   rsp_data;
   logic [CNT_W-1:0]    rsp_cnt;
   logic [SYN_W-1:0]    rsp_syn;
   logic [STATUS_W-1:0] rsp_sts;

   assign rsp_data = rsp_tdata[DATA_W-1:0];
   assign rsp_cnt  = rsp_tdata[CNT_LO +: CNT_W];
   assign rsp_syn  = rsp_tdata[SYN_LO +: SYN_W];
   assign rsp_sts  = rsp_tdata[STS_LO +: STATUS_W];

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response transaction changed");

   a_status_syn: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_sts == STATUS_CLEAN) == (rsp_syn == '0)) &&
                     ((rsp_sts == STATUS_CHECK_ERR) == $onehot(rsp_syn)))
      else $error("status disagrees with syndrome");

   a_data_fit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_cnt != '0) && (int'(rsp_cnt) <= DATA_W) &&
                     ((rsp_data >> rsp_cnt) == '0))
      else $error("data bits exceed data count");

endmodule

bind hamming_codeword_decoder hcd_checker #(
   .MAX_WORD_BITS(MAX_WORD_BITS)
) u_hcd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ test/tb_hamming_codeword_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hamming_codeword_decoder
// Drives codewords through the decoder under a range of codeword lengths and
// checks every response field against a built-in Hamming decoder. Stimulus
// is mostly valid codewords with zero, one or two bit errors and junk above
// the word, plus some fully random words. Sender bursts and receiver stalls
// are random.
// ----------------------------------------------------------------------------
module tb_hamming_codeword_decoder;

   import hcd_pkg::*;

   localparam int MAXW     = DEF_MAX_WORD_BITS;
   localparam int DATA_W   = data_width(MAXW);
   localparam int COUNT_W  = count_width(MAXW);
   localparam int SYN_W    = syn_width(MAXW);
   localparam int REQ_W    = req_width(MAXW);
   localparam int RSP_W    = rsp_width(MAXW);
   localparam int LATENCY  = 4;
   localparam int WDOG_MAX = 5000;
   localparam int RAND_PER_SIZE = 53;

   typedef struct packed {
      logic [DATA_W-1:0]  data_bits;
      logic [COUNT_W-1:0] data_count;
      logic [SYN_W-1:0]   syndrome;
      status_type         status;
   } decode_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_wr_en = 1'b0;
   logic [WORD_SIZE_W-1:0] csr_wr_data = '0;

   logic [63:0]            codeword_backlog[$];
   decode_result_type      expected_results[$];
   logic [WORD_SIZE_W-1:0] cfg_word_size = WORD_SIZE_W'(RESET_WORD_BITS);
   int                     mismatches = 0;

   hamming_codeword_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int word_bits(input logic [WORD_SIZE_W-1:0] size_reg);
      int n;
      n = int'(size_reg);
      if (n < MIN_WORD_BITS) n = MIN_WORD_BITS;
      if (n > MAXW) n = MAXW;
      return n;
   endfunction

   function automatic decode_result_type decode_codeword(input logic [63:0] cw,
                                                         input logic [WORD_SIZE_W-1:0] size_reg);
      decode_result_type r;
      logic [63:0]       w;
      int                n;
      int                syn;
      int                cnt;
      n   = word_bits(size_reg);
      w   = cw;
      syn = 0;
      for (int p = 1; p <= n; p++) begin
         if (w[p-1]) syn = syn ^ p;
      end
      if (syn == 0) begin
         r.status = STATUS_CLEAN;
      end else if ($countones(syn) < 2) begin
         r.status = STATUS_CHECK_ERR;
      end else if (syn > n) begin
         r.status = STATUS_UNCORRECTABLE;
      end else begin
         w[syn-1] = ~w[syn-1];
         r.status = STATUS_CORRECTED;
      end
      r.data_bits = '0;
      cnt = 0;
      for (int p = 1; p <= n; p++) begin
         if ((p & (p - 1)) != 0) begin
            r.data_bits = {r.data_bits[DATA_W-2:0], w[p-1]};
            cnt++;
         end
      end
      r.data_count = COUNT_W'(cnt);
      r.syndrome   = SYN_W'(syn);
      return r;
   endfunction

   // valid codeword with random data, then errors; bits above the word stay random
   function automatic logic [63:0] build_codeword(input int n);
      logic [63:0] w;
      int          syn;
      int          kind;
      int          a;
      int          b;
      w = {$urandom, $urandom};
      for (int k = 0; (1 << k) <= n; k++) w[(1 << k) - 1] = 1'b0;
      syn = 0;
      for (int p = 1; p <= n; p++) begin
         if (w[p-1]) syn = syn ^ p;
      end
      for (int k = 0; (1 << k) <= n; k++) w[(1 << k) - 1] = syn[k];
      kind = $urandom_range(0, 9);
      if (kind >= 4 && kind <= 8) begin
         a = $urandom_range(1, n);
         w[a-1] = ~w[a-1];
         if (kind == 8) begin
            b = $urandom_range(1, n);
            if (b != a) w[b-1] = ~w[b-1];
         end
      end else if (kind == 9) begin
         w = {$urandom, $urandom};
      end
      return w;
   endfunction

   task automatic queue_codeword(input logic [63:0] cw);
      codeword_backlog = {codeword_backlog, cw};
   endtask

   // ---- sender: bursts and gaps ----
   int burst_left = 8;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (codeword_backlog.size() > 0) begin
            req_tdata  <= codeword_backlog.pop_front();
            req_tvalid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---- receiver: stall pattern switches every so often ----
   int rsp_cycle = 0;
   int rsp_mode  = 0;
   int rsp_hold  = 0;

   always @(posedge clock) begin
      rsp_cycle++;
      if (rsp_cycle % 97 == 0) rsp_mode = $urandom_range(0, 3);
      case (rsp_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         2: begin
            rsp_tready <= ((rsp_cycle % 8) >= 3);
         end
         default: begin
            if (rsp_hold == 0) begin
               rsp_hold = $urandom_range(1, 25);
               rsp_tready <= ~rsp_tready;
            end else begin
               rsp_hold--;
            end
         end
      endcase
   end

   // ---- monitor, checker and watchdog ----
   decode_result_type want;
   decode_result_type got;
   int                quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_results = {expected_results, decode_codeword(req_tdata, cfg_word_size)};
         if (rsp_tvalid && rsp_tready) begin
            got.data_bits  = rsp_tdata[DATA_W-1:0];
            got.data_count = rsp_tdata[DATA_W +: COUNT_W];
            got.syndrome   = rsp_tdata[DATA_W+COUNT_W +: SYN_W];
            got.status     = status_type'(rsp_tdata[DATA_W+COUNT_W+SYN_W +: STATUS_W]);
            if (expected_results.size() == 0) begin
               $error("unexpected response transaction: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (got.data_bits !== want.data_bits) begin
                  $error("data_bits: expected %h, got %h", want.data_bits, got.data_bits);
                  mismatches++;
               end
               if (got.data_count !== want.data_count) begin
                  $error("data_count: expected %0d, got %0d", want.data_count,
                         got.data_count);
                  mismatches++;
               end
               if (got.syndrome !== want.syndrome) begin
                  $error("syndrome: expected %0d, got %0d", want.syndrome, got.syndrome);
                  mismatches++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  mismatches++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WDOG_MAX) begin
            $display("tb_hamming_codeword_decoder NOT OK");
            $finish;
         end
      end
   end

   // ---- sequencing ----
   task automatic wait_drained();
      while (codeword_backlog.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(negedge clock);
      repeat (2 * LATENCY) @(negedge clock);
   endtask

   task automatic write_word_size(input logic [WORD_SIZE_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_word_size = v;
      @(negedge clock);
   endtask

   int size_plan[15] = '{12, 64, 3, 0, 127, 2, 65, 1, 7, 16, 15, 32, 33, 57, 12};

   initial begin
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int ph = 0; ph < 15; ph++) begin
         if (ph > 0) begin
            wait_drained();
            write_word_size(WORD_SIZE_W'(size_plan[ph]));
         end
         n = word_bits(cfg_word_size);
         if (ph == 0) begin
            // clean, all ones, check-bit flips, data flips, syndrome past word, junk above
            queue_codeword(64'h0);
            queue_codeword('1);
            queue_codeword(64'h1);
            queue_codeword(64'h2);
            queue_codeword(64'h8);
            queue_codeword(64'h80);
            queue_codeword(64'h4);
            queue_codeword(64'h800);
            queue_codeword(64'h89);
            queue_codeword(64'h804);
            queue_codeword(64'hFFFF_FFFF_FFFF_F000);
            queue_codeword(build_codeword(n));
         end else if (size_plan[ph] == 64) begin
            queue_codeword(64'h0);
            queue_codeword('1);
            queue_codeword(64'h8000_0000_0000_0000);
            queue_codeword(64'h4000_0000_0000_0000);
            queue_codeword(64'h8000_0000_0000_0001);
            queue_codeword(64'hC000_0000_0000_0000);
         end else if (size_plan[ph] == 3) begin
            queue_codeword(64'h4);
            queue_codeword(64'h3);
            queue_codeword(64'h7);
            queue_codeword(64'hFFFF_FFFF_FFFF_FFF8);
         end
         for (int k = 0; k < RAND_PER_SIZE; k++) begin
            queue_codeword(build_codeword(n));
            // hold the sender once mid-run until every response is back
            if (ph == 1 && k == RAND_PER_SIZE / 2) wait_drained();
         end
      end
      wait_drained();
      if (mismatches == 0 && expected_results.size() == 0)
         $display("tb_hamming_codeword_decoder OK");
      else
         $display("tb_hamming_codeword_decoder NOT OK");
      $finish;
   end

endmodule
